[src/xbr_pkg.sv]
// xbr_pkg: shared types and constants of the xmodem block receiver
// no dependencies; used by the interfaces, the core, the queue and the top level
package xbr_pkg;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_TICK   = 2'd1,
    OP_START  = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_START = 8'b0000_0010,
    PH_HDR   = 8'b0000_0100,
    PH_SEQ1  = 8'b0000_1000,
    PH_SEQ2  = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CHK1  = 8'b0100_0000,
    PH_CHK2  = 8'b1000_0000
  } phase_t;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SEQ_MASK = 8'hff;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_COMMITTED = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_REJECTED  = 3'd3;
  localparam logic [2:0] ST_COMPLETE  = 3'd4;
  localparam logic [2:0] ST_SENDER    = 3'd5;
  localparam logic [2:0] ST_ABORTED   = 3'd6;
  localparam logic [2:0] ST_USER      = 3'd7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int TRY_W  = 5;

  localparam logic REG_CRC_ATTEMPTS      = 1'b0;
  localparam logic REG_CHECKSUM_ATTEMPTS = 1'b1;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       last;
  } result_t;

endpackage

[src/xbr_if.sv]
// xbr_if: valid/ready channels for input items and result items
// depends on xbr_pkg
interface xbr_cmd_if;
  logic             valid;
  logic             ready;
  xbr_pkg::op_t     op;
  logic [7:0]       rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface xbr_res_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output tx_valid, output tx_byte, output data_valid,
                  output data_byte, output status, output last, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input data_valid,
                input data_byte, input status, input last, output ready);
endinterface

[src/xbr_core.sv]
// xbr_core: input register, protocol state and one-pass step logic
// depends on xbr_pkg; produces up to two results per item for the queue
module xbr_core #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  xbr_pkg::op_t               in_op,
  input  logic [7:0]                 in_byte,
  input  logic [xbr_pkg::TRY_W-1:0]  crc_attempts,
  input  logic [xbr_pkg::TRY_W-1:0]  checksum_attempts,
  output logic [1:0]                 push_cnt,
  output xbr_pkg::result_t           push0,
  output xbr_pkg::result_t           push1
);

  localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
  localparam int TW    = xbr_pkg::TRY_W;

  typedef struct packed {
    logic             crc_mode;
    logic [TW-1:0]    try_count;
    logic             to_idle;
    xbr_pkg::result_t res;
  } req_t;

  logic              s1_valid;
  xbr_pkg::op_t      s1_op;
  logic [7:0]        s1_byte;

  xbr_pkg::phase_t   phase, phase_next;
  logic [TW-1:0]     try_count, try_count_next;
  logic              crc_mode, crc_mode_next;
  logic [7:0]        expected_seq, expected_seq_next;
  logic [7:0]        seq_first, seq_first_next;
  logic [7:0]        seq_second, seq_second_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [15:0]       crc_acc, crc_acc_next;
  logic [7:0]        sum_acc, sum_acc_next;
  logic [7:0]        rx_check, rx_check_next;

  req_t              rq;
  logic              chk_ok;
  logic              seq_comp;
  xbr_pkg::result_t  vd_res;
  logic              vd_adv;
  xbr_pkg::result_t  r0, r1;
  logic [1:0]        n;

  function automatic xbr_pkg::result_t mk(logic txv, logic [7:0] txb, logic [2:0] st);
    xbr_pkg::result_t r;
    r = '0;
    r.tx_valid = txv;
    r.tx_byte  = txb;
    r.status   = st;
    return r;
  endfunction

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ xbr_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic req_t request(logic crc, logic [TW-1:0] tries,
                                   logic [TW-1:0] crc_lim, logic [TW-1:0] sum_lim);
    req_t r;
    logic c;
    logic [TW-1:0] t;
    c = crc;
    t = tries;
    r = '0;
    if (c && (t < crc_lim)) begin
      r.crc_mode  = 1'b1;
      r.try_count = t + TW'(1);
      r.res       = mk(1'b1, xbr_pkg::CH_C, xbr_pkg::ST_NONE);
    end else begin
      if (c) begin
        c = 1'b0;
        t = '0;
      end
      r.crc_mode = c;
      if (t < sum_lim) begin
        r.try_count = t + TW'(1);
        r.res       = mk(1'b1, xbr_pkg::CH_NAK, xbr_pkg::ST_NONE);
      end else begin
        r.try_count = t;
        r.to_idle   = 1'b1;
        r.res       = mk(1'b0, 8'h00, xbr_pkg::ST_ABORTED);
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      phase        <= xbr_pkg::PH_IDLE;
      try_count    <= '0;
      crc_mode     <= 1'b1;
      expected_seq <= 8'd1;
    end else begin
      s1_valid     <= accept;
      phase        <= phase_next;
      try_count    <= try_count_next;
      crc_mode     <= crc_mode_next;
      expected_seq <= expected_seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= in_op;
      s1_byte <= in_byte;
    end
    seq_first  <= seq_first_next;
    seq_second <= seq_second_next;
    byte_count <= byte_count_next;
    crc_acc    <= crc_acc_next;
    sum_acc    <= sum_acc_next;
    rx_check   <= rx_check_next;
  end

  // request shared by start and timeout in the start phase
  always_comb begin
    if (s1_op == xbr_pkg::OP_START) begin
      rq = request(1'b1, '0, crc_attempts, checksum_attempts);
    end else begin
      rq = request(crc_mode, try_count, crc_attempts, checksum_attempts);
    end
  end

  // block verdict on the last check byte
  always_comb begin
    if (crc_mode) begin
      chk_ok = (crc_acc == {rx_check, s1_byte});
    end else begin
      chk_ok = (sum_acc == s1_byte);
    end
    seq_comp = ((seq_first ^ seq_second) == xbr_pkg::SEQ_MASK);
    vd_adv   = 1'b0;
    if (chk_ok && seq_comp && (seq_first == expected_seq - 8'd1)) begin
      vd_res = mk(1'b1, xbr_pkg::CH_ACK, xbr_pkg::ST_DUPLICATE);
    end else if (!chk_ok || !seq_comp || (seq_first != expected_seq)) begin
      vd_res = mk(1'b1, xbr_pkg::CH_NAK, xbr_pkg::ST_REJECTED);
    end else begin
      vd_res = mk(1'b1, xbr_pkg::CH_ACK, xbr_pkg::ST_COMMITTED);
      vd_adv = 1'b1;
    end
  end

  always_comb begin
    phase_next        = phase;
    try_count_next    = try_count;
    crc_mode_next     = crc_mode;
    expected_seq_next = expected_seq;
    seq_first_next    = seq_first;
    seq_second_next   = seq_second;
    byte_count_next   = byte_count;
    crc_acc_next      = crc_acc;
    sum_acc_next      = sum_acc;
    rx_check_next     = rx_check;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (s1_valid) begin
      unique case (s1_op)
        xbr_pkg::OP_BYTE: begin
          unique case (phase)
            xbr_pkg::PH_START, xbr_pkg::PH_HDR: begin
              if (s1_byte == xbr_pkg::CH_SOH) begin
                seq_first_next  = '0;
                seq_second_next = '0;
                byte_count_next = '0;
                crc_acc_next    = '0;
                sum_acc_next    = '0;
                rx_check_next   = '0;
                phase_next      = xbr_pkg::PH_SEQ1;
              end else begin
                phase_next = xbr_pkg::PH_IDLE;
                n = 2'd1;
                priority if (s1_byte == xbr_pkg::CH_EOT) begin
                  r0 = mk(1'b1, xbr_pkg::CH_ACK, xbr_pkg::ST_COMPLETE);
                end else if (s1_byte == xbr_pkg::CH_CAN) begin
                  r0 = mk(1'b0, 8'h00, xbr_pkg::ST_SENDER);
                end else begin
                  r0 = mk(1'b0, 8'h00, xbr_pkg::ST_ABORTED);
                end
              end
            end
            xbr_pkg::PH_SEQ1: begin
              seq_first_next = s1_byte;
              phase_next     = xbr_pkg::PH_SEQ2;
            end
            xbr_pkg::PH_SEQ2: begin
              seq_second_next = s1_byte;
              phase_next      = xbr_pkg::PH_DATA;
            end
            xbr_pkg::PH_DATA: begin
              crc_acc_next    = crc_step(crc_acc, s1_byte);
              sum_acc_next    = sum_acc + s1_byte;
              byte_count_next = byte_count + CNT_W'(1);
              if (byte_count == CNT_W'(BLOCK_BYTES - 1)) begin
                phase_next = xbr_pkg::PH_CHK1;
              end
              n = 2'd1;
              r0.data_valid = 1'b1;
              r0.data_byte  = s1_byte;
            end
            xbr_pkg::PH_CHK1: begin
              rx_check_next = s1_byte;
              if (crc_mode) begin
                phase_next = xbr_pkg::PH_CHK2;
              end else begin
                phase_next = xbr_pkg::PH_HDR;
                n  = 2'd1;
                r0 = vd_res;
                if (vd_adv) begin
                  expected_seq_next = expected_seq + 8'd1;
                end
              end
            end
            xbr_pkg::PH_CHK2: begin
              phase_next = xbr_pkg::PH_HDR;
              n  = 2'd1;
              r0 = vd_res;
              if (vd_adv) begin
                expected_seq_next = expected_seq + 8'd1;
              end
            end
            default: begin
            end
          endcase
        end
        xbr_pkg::OP_TICK: begin
          unique case (phase)
            xbr_pkg::PH_START: begin
              crc_mode_next  = rq.crc_mode;
              try_count_next = rq.try_count;
              if (rq.to_idle) begin
                phase_next = xbr_pkg::PH_IDLE;
              end
              n  = 2'd1;
              r0 = rq.res;
            end
            xbr_pkg::PH_HDR: begin
              phase_next = xbr_pkg::PH_IDLE;
              n  = 2'd1;
              r0 = mk(1'b0, 8'h00, xbr_pkg::ST_ABORTED);
            end
            xbr_pkg::PH_DATA: begin
              phase_next = xbr_pkg::PH_HDR;
              n  = 2'd2;
              r0 = mk(1'b1, xbr_pkg::CH_CAN, xbr_pkg::ST_NONE);
              r1 = mk(1'b1, xbr_pkg::CH_NAK, xbr_pkg::ST_REJECTED);
            end
            xbr_pkg::PH_SEQ1, xbr_pkg::PH_SEQ2, xbr_pkg::PH_CHK1, xbr_pkg::PH_CHK2: begin
              phase_next = xbr_pkg::PH_HDR;
              n  = 2'd1;
              r0 = mk(1'b1, xbr_pkg::CH_NAK, xbr_pkg::ST_REJECTED);
            end
            default: begin
            end
          endcase
        end
        xbr_pkg::OP_START: begin
          expected_seq_next = 8'd1;
          crc_mode_next     = rq.crc_mode;
          try_count_next    = rq.try_count;
          phase_next        = rq.to_idle ? xbr_pkg::PH_IDLE : xbr_pkg::PH_START;
          n  = 2'd1;
          r0 = rq.res;
        end
        xbr_pkg::OP_CANCEL: begin
          if ((phase == xbr_pkg::PH_START) || (phase == xbr_pkg::PH_HDR)) begin
            phase_next = xbr_pkg::PH_IDLE;
            n  = 2'd1;
            r0 = mk(1'b0, 8'h00, xbr_pkg::ST_USER);
          end else if (phase != xbr_pkg::PH_IDLE) begin
            phase_next = xbr_pkg::PH_IDLE;
            n  = 2'd1;
            r0 = mk(1'b1, xbr_pkg::CH_CAN, xbr_pkg::ST_USER);
          end
        end
        default: begin
        end
      endcase
    end
    r0.last = (n == 2'd1);
    r1.last = (n == 2'd2);
  end

  assign push_cnt = n;
  assign push0    = r0;
  assign push1    = r1;

endmodule

[src/xbr_queue.sv]
// xbr_queue: small result queue taking up to two results per cycle
// depends on xbr_pkg
module xbr_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   push_cnt,
  input  xbr_pkg::result_t             push0,
  input  xbr_pkg::result_t             push1,
  input  logic                         pop,
  output logic                         out_valid,
  output xbr_pkg::result_t             out_data,
  output logic [xbr_pkg::QFILL_W-1:0]  fill
);

  localparam int PW = xbr_pkg::QPTR_W;
  localparam int CW = xbr_pkg::QFILL_W;

  xbr_pkg::result_t mem [xbr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_pop;

  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_cnt);
      rd_ptr <= rd_ptr + PW'(do_pop);
      count  <= count + CW'(push_cnt) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push1;
    end
  end

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign fill      = count;

endmodule

[src/xmodem_block_receiver.sv]
// XMODEM block receiver. One item (received byte, timeout tick, start or user
// cancel) is accepted per clock; it is registered, handled in one pass over the
// protocol state in the following cycle, and its one or two results enter a
// four-entry result queue; the first result is offered once it is queued
// and can be taken at the next clock edge. cmd.ready drops when the queue plus
// the results being written would leave no room for two more: while res.ready
// is held low, and also with res.ready high when a timeout inside the data
// writes its pair behind a result still waiting. CRC-16/XMODEM is updated
// eight bits per item in that single pass. Configuration goes through the APB
// port at byte addresses 0 (crc_attempts) and 4 (checksum_attempts), to be
// written by the user only while the block is idle, which it does not enforce.
// depends on xbr_pkg, xbr_if, xbr_core and xbr_queue
module xmodem_block_receiver #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  xbr_cmd_if.sink                      cmd,
  xbr_res_if.source                    res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [xbr_pkg::APB_AW-1:0]   paddr,
  input  logic [xbr_pkg::APB_DW-1:0]   pwdata,
  output logic [xbr_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int TW = xbr_pkg::TRY_W;
  localparam int CW = xbr_pkg::QFILL_W;

  logic [TW-1:0]     crc_attempts;
  logic [TW-1:0]     checksum_attempts;
  logic              accept;
  logic [1:0]        push_cnt;
  xbr_pkg::result_t  push0, push1;
  xbr_pkg::result_t  head;
  logic              head_valid;
  logic [CW-1:0]     fill;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_attempts      <= TW'(10);
      checksum_attempts <= TW'(10);
    end else if (cfg_wr) begin
      if (paddr[2] == xbr_pkg::REG_CRC_ATTEMPTS) begin
        crc_attempts <= pwdata[TW-1:0];
      end else begin
        checksum_attempts <= pwdata[TW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == xbr_pkg::REG_CRC_ATTEMPTS) begin
      prdata[TW-1:0] = crc_attempts;
    end else begin
      prdata[TW-1:0] = checksum_attempts;
    end
  end

  assign cmd.ready = ((fill + CW'(push_cnt)) <= CW'(xbr_pkg::QUEUE_DEPTH - 2));
  assign accept    = cmd.valid && cmd.ready;

  xbr_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .in_op            (cmd.op),
    .in_byte          (cmd.rx_byte),
    .crc_attempts     (crc_attempts),
    .checksum_attempts(checksum_attempts),
    .push_cnt         (push_cnt),
    .push0            (push0),
    .push1            (push1)
  );

  xbr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push0    (push0),
    .push1    (push1),
    .pop      (res.ready),
    .out_valid(head_valid),
    .out_data (head),
    .fill     (fill)
  );

  assign res.valid      = head_valid;
  assign res.tx_valid   = head.tx_valid;
  assign res.tx_byte    = head.tx_byte;
  assign res.data_valid = head.data_valid;
  assign res.data_byte  = head.data_byte;
  assign res.status     = head.status;
  assign res.last       = head.last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(xbr_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_room_for_pair: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((fill + CW'(push_cnt)) <= CW'(xbr_pkg::QUEUE_DEPTH)))
    else $error("queue room not reserved for accepted item");

  a_first_of_pair: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last) |-> (res.tx_valid && (res.tx_byte == xbr_pkg::CH_CAN)))
    else $error("non-final result is not a cancel");

  a_data_alone: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data_valid) |-> (!res.tx_valid && res.last &&
                                       (res.status == xbr_pkg::ST_NONE)))
    else $error("payload result carries control fields");

endmodule
